@@ design/fpid_pkg.sv @@
// fpid_pkg: shared types and constants of the fan pid speed controller
// used by fpid_track, fpid_terms, fpid_speed and fan_pid_speed_controller

package fpid_pkg;

  localparam int READ_W  = 18;
  localparam int TEMP_W  = 7;
  localparam int GAIN_W  = 16;
  localparam int SPEED_W = 7;
  localparam int ERR_W   = 19;
  localparam int DIFF_W  = 20;
  localparam int MILLI_W = 17;
  localparam int ISUM_W  = 42;

  localparam int PTERM_W = GAIN_W + 1 + ERR_W;
  localparam int ITERM_W = GAIN_W + 1 + ISUM_W;
  localparam int DTERM_W = GAIN_W + 1 + DIFF_W;
  localparam int TOTAL_W = 60;

  localparam int MILLI = 1000;

  localparam logic [TEMP_W-1:0] TARGET_RESET = 7'd52;
  localparam logic [GAIN_W-1:0] PROP_RESET   = 16'd13107;
  localparam logic [GAIN_W-1:0] INTEG_RESET  = 16'd983;
  localparam logic [GAIN_W-1:0] DERIV_RESET  = 16'd13107;

  localparam logic [SPEED_W-1:0] SPEED_LOW  = 7'd16;
  localparam logic [SPEED_W-1:0] SPEED_HIGH = 7'd112;

  // one unit of speed is 1000 * 2^16 in the gain-scaled sum
  localparam logic signed [TOTAL_W-1:0] SCALE_ONE  = 60'sd65536000;
  localparam logic signed [TOTAL_W-1:0] SCALE_HIGH = 60'sd7340032000;

  // floor(x / 1000) for x below 2^17 as (x * RECIP) >> RECIP_SHIFT
  localparam int QIN_W       = 17;
  localparam int QPROD_W     = 35;
  localparam int RECIP_SHIFT = 27;
  localparam logic [QPROD_W-1:0] RECIP = 35'd134218;

  typedef enum logic [1:0] {
    REG_TARGET     = 2'd0,
    REG_PROP_GAIN  = 2'd1,
    REG_INTEG_GAIN = 2'd2,
    REG_DERIV_GAIN = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [TEMP_W-1:0] target;
    logic [GAIN_W-1:0] prop;
    logic [GAIN_W-1:0] integ;
    logic [GAIN_W-1:0] deriv;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic signed [ISUM_W-1:0] isum;
    logic [READ_W-1:0]        max;
  } step_t;

  typedef struct packed {
    logic signed [PTERM_W-1:0] pterm;
    logic signed [ITERM_W-1:0] iterm;
    logic signed [DTERM_W-1:0] dterm;
    logic [READ_W-1:0]         max;
  } terms_t;

  typedef struct packed {
    logic              low;
    logic              high;
    logic [QIN_W-1:0]  quot_in;
    logic [READ_W-1:0] max;
  } sum_t;

endpackage

@@ design/fpid_track.sv @@
// fpid_track: scan maximum, error, saturating integral and previous error
// depends on fpid_pkg

module fpid_track #(
  parameter int INTEGRAL_BITS = 40
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [fpid_pkg::READ_W-1:0] in_reading_i,
  input  logic                       in_present_i,
  input  logic                       in_last_i,
  input  fpid_pkg::cfg_t             cfg_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output fpid_pkg::step_t            out_o
);

  localparam int SUM_W = INTEGRAL_BITS + 1;
  localparam logic signed [INTEGRAL_BITS-1:0] INT_MIN = {1'b1, {(INTEGRAL_BITS-1){1'b0}}};
  localparam logic signed [INTEGRAL_BITS-1:0] INT_MAX = {1'b0, {(INTEGRAL_BITS-1){1'b1}}};

  logic [fpid_pkg::READ_W-1:0]        scan_max_q, scan_max_d;
  logic signed [fpid_pkg::ERR_W-1:0]  prev_err_q;
  logic signed [INTEGRAL_BITS-1:0]    err_sum_q, err_sum_d;
  logic                               valid_q;
  fpid_pkg::step_t                    step_q, step_d;

  logic [fpid_pkg::MILLI_W-1:0]       tgt_milli;
  logic signed [fpid_pkg::ERR_W-1:0]  err;
  logic signed [SUM_W-1:0]            wide_sum;
  logic signed [fpid_pkg::ISUM_W-1:0] isum_lim;
  logic                               fire;

  assign in_ready_o = !valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    if (in_present_i && (in_reading_i > scan_max_q)) begin
      scan_max_d = in_reading_i;
    end else begin
      scan_max_d = scan_max_q;
    end
  end

  assign tgt_milli = fpid_pkg::MILLI_W'(cfg_i.target) * fpid_pkg::MILLI_W'(fpid_pkg::MILLI);
  assign err = signed'(fpid_pkg::ERR_W'(tgt_milli)) - signed'(fpid_pkg::ERR_W'(scan_max_d));

  // saturating integral: overflow when the two top bits of the wide sum differ
  assign wide_sum = SUM_W'(err_sum_q) + SUM_W'(err);

  always_comb begin
    if (wide_sum[INTEGRAL_BITS] != wide_sum[INTEGRAL_BITS-1]) begin
      err_sum_d = wide_sum[INTEGRAL_BITS] ? INT_MIN : INT_MAX;
    end else begin
      err_sum_d = wide_sum[INTEGRAL_BITS-1:0];
    end
  end

  always_comb begin
    step_d.err  = err;
    step_d.diff = fpid_pkg::DIFF_W'(err) - fpid_pkg::DIFF_W'(prev_err_q);
    step_d.isum = isum_lim;
    step_d.max  = scan_max_d;
  end

  // integral term input is limited to +-2^40, which only a wide sum can reach
  if (INTEGRAL_BITS > 41) begin : g_clamp
    localparam logic signed [INTEGRAL_BITS-1:0] CLAMP_POS =
      {{(INTEGRAL_BITS-41){1'b0}}, 1'b1, 40'b0};
    localparam logic signed [INTEGRAL_BITS-1:0] CLAMP_NEG = -CLAMP_POS;
    always_comb begin
      if (err_sum_d > CLAMP_POS) begin
        isum_lim = fpid_pkg::ISUM_W'(CLAMP_POS);
      end else if (err_sum_d < CLAMP_NEG) begin
        isum_lim = fpid_pkg::ISUM_W'(CLAMP_NEG);
      end else begin
        isum_lim = fpid_pkg::ISUM_W'(err_sum_d);
      end
    end
  end else begin : g_extend
    assign isum_lim = fpid_pkg::ISUM_W'(err_sum_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_max_q <= '0;
      prev_err_q <= '0;
      err_sum_q  <= '0;
      valid_q    <= 1'b0;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i && in_last_i;
      end
      if (fire) begin
        if (in_last_i) begin
          scan_max_q <= '0;
          prev_err_q <= err;
          err_sum_q  <= err_sum_d;
        end else begin
          scan_max_q <= scan_max_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_last_i) begin
      step_q <= step_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = step_q;

endmodule

@@ design/fpid_terms.sv @@
// fpid_terms: proportional, integral and derivative products, registered
// depends on fpid_pkg

module fpid_terms (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fpid_pkg::step_t   in_i,
  input  fpid_pkg::cfg_t    cfg_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fpid_pkg::terms_t  out_o
);

  logic             valid_q;
  fpid_pkg::terms_t terms_q, terms_d;
  logic             fire;

  assign in_ready_o = !valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  // gains are unsigned, so they enter the signed products with a zero on top
  always_comb begin
    terms_d.pterm = fpid_pkg::PTERM_W'(signed'({1'b0, cfg_i.prop}))
                  * fpid_pkg::PTERM_W'(in_i.err);
    terms_d.iterm = fpid_pkg::ITERM_W'(signed'({1'b0, cfg_i.integ}))
                  * fpid_pkg::ITERM_W'(in_i.isum);
    terms_d.dterm = fpid_pkg::DTERM_W'(signed'({1'b0, cfg_i.deriv}))
                  * fpid_pkg::DTERM_W'(in_i.diff);
    terms_d.max   = in_i.max;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      terms_q <= terms_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = terms_q;

endmodule

@@ design/fpid_speed.sv @@
// fpid_speed: sums the terms, clamps and scales to a fan duty value
// two registered stages, the second is the output register; depends on fpid_pkg

module fpid_speed (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  fpid_pkg::terms_t             in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [fpid_pkg::SPEED_W-1:0] out_speed_o,
  output logic [fpid_pkg::READ_W-1:0]  out_max_o
);

  logic                              sum_valid_q;
  fpid_pkg::sum_t                    sum_q, sum_d;
  logic                              sum_ready, sum_fire;
  logic signed [fpid_pkg::TOTAL_W-1:0] total, speed_scaled;

  logic                              out_valid_q;
  logic [fpid_pkg::SPEED_W-1:0]      speed_q, speed_d;
  logic [fpid_pkg::READ_W-1:0]       max_q;
  logic [fpid_pkg::QPROD_W-1:0]      quot_prod;
  logic                              out_fire;

  // sum stage
  assign in_ready_o = !sum_valid_q || sum_ready;
  assign sum_fire   = in_valid_i && in_ready_o;

  assign total = fpid_pkg::TOTAL_W'(in_i.pterm) + fpid_pkg::TOTAL_W'(in_i.iterm)
               + fpid_pkg::TOTAL_W'(in_i.dterm);
  assign speed_scaled = -total;

  always_comb begin
    sum_d.low     = speed_scaled <= fpid_pkg::SCALE_ONE;
    sum_d.high    = speed_scaled > fpid_pkg::SCALE_HIGH;
    // in range the value is below 2^33, so bits 32:16 hold it divided by 2^16
    sum_d.quot_in = speed_scaled[16 +: fpid_pkg::QIN_W];
    sum_d.max     = in_i.max;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      sum_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_fire) begin
      sum_q <= sum_d;
    end
  end

  // output stage: divide by 1000 through the reciprocal
  assign sum_ready = !out_valid_q || out_ready_i;
  assign out_fire  = sum_valid_q && sum_ready;

  assign quot_prod = fpid_pkg::QPROD_W'(sum_q.quot_in) * fpid_pkg::RECIP;

  always_comb begin
    priority if (sum_q.low) begin
      speed_d = fpid_pkg::SPEED_LOW;
    end else if (sum_q.high) begin
      speed_d = fpid_pkg::SPEED_HIGH;
    end else begin
      speed_d = quot_prod[fpid_pkg::RECIP_SHIFT +: fpid_pkg::SPEED_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sum_ready) begin
      out_valid_q <= sum_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      speed_q <= speed_d;
      max_q   <= sum_q.max;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_speed_o = speed_q;
  assign out_max_o   = max_q;

endmodule

@@ design/fan_pid_speed_controller.sv @@
// fan_pid_speed_controller: top level, depends on fpid_pkg, fpid_track,
// fpid_terms and fpid_speed.
// Sensor readings arrive as beats on the s_axis channel, one sensor per beat:
// tdata holds the reading in millidegrees, tuser says the sensor is present,
// tlast closes a scan. Only the closing beat of a scan yields a result beat
// on m_axis: the clamped fan speed and the largest present reading of the scan.
// The apb port holds target temperature and the three Q0.16 gains; write it
// only while no scan result is outstanding.
// Throughput: one beat per cycle until back-pressure from m_axis fills every
// stage. A closing beat passes the input register, integral stage, product
// stage, sum stage and output register in that order. The integral update is a
// single saturating add into the INTEGRAL_BITS-wide integral, done once per scan.
// Reset clears the scan maximum, the integral and the previous error and
// loads the register defaults. When m_axis stalls, every stage holds its beat
// and empty stages behind it keep filling; s_axis tready drops only once all
// stages are full.

module fan_pid_speed_controller #(
  parameter int INTEGRAL_BITS = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // sensor_reading[17:0], zero fill
  input  logic [0:0]  s_axis_tuser,   // sensor_present[0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // fan_speed[6:0], scan_max_temp[24:7], zero fill
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  fpid_pkg::cfg_t cfg_q;
  fpid_pkg::reg_idx_e reg_idx;
  logic cfg_write;

  logic                        in_valid_q;
  logic [fpid_pkg::READ_W-1:0] reading_q;
  logic                        present_q;
  logic                        last_q;

  logic             trk_ready, trk_valid;
  fpid_pkg::step_t  trk_step;
  logic             trm_ready, trm_valid;
  fpid_pkg::terms_t trm_terms;
  logic             spd_ready;
  logic [fpid_pkg::SPEED_W-1:0] speed;
  logic [fpid_pkg::READ_W-1:0]  scan_max;

  // configuration registers
  assign pready    = 1'b1;
  assign reg_idx   = fpid_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target <= fpid_pkg::TARGET_RESET;
      cfg_q.prop   <= fpid_pkg::PROP_RESET;
      cfg_q.integ  <= fpid_pkg::INTEG_RESET;
      cfg_q.deriv  <= fpid_pkg::DERIV_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        fpid_pkg::REG_TARGET:     cfg_q.target <= pwdata[fpid_pkg::TEMP_W-1:0];
        fpid_pkg::REG_PROP_GAIN:  cfg_q.prop   <= pwdata[fpid_pkg::GAIN_W-1:0];
        fpid_pkg::REG_INTEG_GAIN: cfg_q.integ  <= pwdata[fpid_pkg::GAIN_W-1:0];
        fpid_pkg::REG_DERIV_GAIN: cfg_q.deriv  <= pwdata[fpid_pkg::GAIN_W-1:0];
        default:                  cfg_q        <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      fpid_pkg::REG_TARGET:     prdata = 32'(cfg_q.target);
      fpid_pkg::REG_PROP_GAIN:  prdata = 32'(cfg_q.prop);
      fpid_pkg::REG_INTEG_GAIN: prdata = 32'(cfg_q.integ);
      fpid_pkg::REG_DERIV_GAIN: prdata = 32'(cfg_q.deriv);
      default:                  prdata = '0;
    endcase
  end

  // input register
  assign s_axis_tready = !in_valid_q || trk_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      reading_q <= s_axis_tdata[fpid_pkg::READ_W-1:0];
      present_q <= s_axis_tuser[0];
      last_q    <= s_axis_tlast;
    end
  end

  fpid_track #(
    .INTEGRAL_BITS(INTEGRAL_BITS)
  ) u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_q),
    .in_ready_o   (trk_ready),
    .in_reading_i (reading_q),
    .in_present_i (present_q),
    .in_last_i    (last_q),
    .cfg_i        (cfg_q),
    .out_valid_o  (trk_valid),
    .out_ready_i  (trm_ready),
    .out_o        (trk_step)
  );

  fpid_terms u_terms (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (trk_valid),
    .in_ready_o  (trm_ready),
    .in_i        (trk_step),
    .cfg_i       (cfg_q),
    .out_valid_o (trm_valid),
    .out_ready_i (spd_ready),
    .out_o       (trm_terms)
  );

  fpid_speed u_speed (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (trm_valid),
    .in_ready_o  (spd_ready),
    .in_i        (trm_terms),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_speed_o (speed),
    .out_max_o   (scan_max)
  );

  assign m_axis_tdata = {7'b0, scan_max, speed};

endmodule
